// File: rtl/core/ida_pkg.sv
package ida_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int CNT_W   = 5;

    // action codes
    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_DROP   = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [2:0]               action;
        logic [POS_W-1:0]         position;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] read_value;
        logic [CNT_W-1:0]          count;
    } t_rsp;

    // per-cell update controls
    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_down;
    } t_cell_ctl;

endpackage

// File: rtl/core/ida_cell.sv
module ida_cell import ida_pkg::*; (
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [VALUE_W-1:0] i_from_lo,
    input  logic signed [VALUE_W-1:0] i_from_hi,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic signed [VALUE_W-1:0] o_entry
);

    logic signed [VALUE_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_value;
        end else if (i_ctl.shift_up) begin
            r_entry <= i_from_lo;
        end else if (i_ctl.shift_down) begin
            r_entry <= i_from_hi;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: rtl/core/insert_delete_array_unit.sv
// Latency: a request accepted at one edge has its result on o_rsp, marked by
//   o_valid, during the following cycle only.
// Throughput: one request per cycle; busy stays low. The whole cell row
//   shifts or loads in the same edge that accepts the request.
// Reset: synchronous, active low; clears the entry count and the strobe.
//   Entry contents are left as they are and are never read before written.
module insert_delete_array_unit import ida_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    // count width holds CAPACITY itself; compares run at the wider of it and POS_W
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                      accept;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_valid;
    t_rsp                      r_rsp;
    logic [1:0]                n_status;
    logic signed [VALUE_W-1:0] n_read;
    logic                      do_append;
    logic                      do_insert;
    logic                      do_delete;
    logic [PW-1:0]             pos_w;
    logic [PW-1:0]             cnt_w;
    logic [PW-1:0]             cap_w;

    logic signed [VALUE_W-1:0] w_entry [CAPACITY];

    // busy is tied low: the command never stalls the requester
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pos_w = PW'(i_req.position);
    assign cnt_w = PW'(r_count);
    assign cap_w = PW'(CAPACITY);

    // action decode and status; rejected requests leave the row untouched
    always_comb begin
        n_status  = ST_OK;
        n_read    = '0;
        n_count   = r_count;
        do_append = 1'b0;
        do_insert = 1'b0;
        do_delete = 1'b0;
        case (i_req.action)
            ACT_APPEND: begin
                if (cnt_w >= cap_w) begin
                    n_status = ST_FULL;
                end else begin
                    do_append = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            ACT_INSERT: begin
                // position check wins over full
                if (pos_w > cnt_w) begin
                    n_status = ST_RANGE;
                end else if (cnt_w >= cap_w) begin
                    n_status = ST_FULL;
                end else begin
                    do_insert = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            ACT_DELETE: begin
                // empty check wins over position
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    n_status = ST_RANGE;
                end else begin
                    do_delete = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            ACT_DROP: begin
                // vacated cell is beyond the count and never read again unwritten
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            ACT_READ: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    n_status = ST_RANGE;
                end else begin
                    n_read = w_entry[pos_w[IW-1:0]];
                end
            end
            default: begin
                // unknown action: no change, status ok
            end
        endcase
    end

    // cell row: insert shifts cells above the position up, delete pulls them down
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [PW-1:0] IDX = PW'(i);
        t_cell_ctl                 ctl;
        logic signed [VALUE_W-1:0] from_lo;
        logic signed [VALUE_W-1:0] from_hi;

        assign ctl.load       = accept && ((do_append && IDX == cnt_w)
                                        || (do_insert && IDX == pos_w));
        assign ctl.shift_up   = accept && do_insert && (IDX > pos_w);
        assign ctl.shift_down = accept && do_delete && (IDX >= pos_w);

        if (i == 0) begin : g_lo_edge
            assign from_lo = '0;
        end else begin : g_lo
            assign from_lo = w_entry[i-1];
        end

        if (i == CAPACITY - 1) begin : g_hi_edge
            assign from_hi = '0;
        end else begin : g_hi
            assign from_hi = w_entry[i+1];
        end

        ida_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_from_lo (from_lo),
            .i_from_hi (from_hi),
            .i_value   (i_req.value),
            .o_entry   (w_entry[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp.status     <= n_status;
            r_rsp.read_value <= n_read;
            r_rsp.count      <= CNT_W'(n_count);
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// File: rtl/core/ida_checker.sv
module ida_checker import ida_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_rsp o_rsp
);

    // one result per accepted request, in the cycle after it
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("no result after accepted request");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("result without request");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == ST_EMPTY) |-> (o_rsp.count == '0))
        else $error("empty status with nonzero count");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != ST_OK) |-> (o_rsp.read_value == '0))
        else $error("rejected request returned data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == ST_FULL) |-> (o_rsp.count == CNT_W'(CAPACITY)))
        else $error("full status below capacity");

endmodule

bind insert_delete_array_unit ida_checker #(.CAPACITY(CAPACITY)) u_ida_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

// File: tb/tb.sv
module tb;
    import ida_pkg::*;

    localparam int CAPACITY = 16;

    // action codes the block must ignore (outside the defined set)
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    localparam int RANDOM_REQS = 800;

    // random phase mix: grow the list, shrink it, or stir it evenly
    typedef enum logic [1:0] {
        FILL_UP,
        DRAIN,
        CHURN
    } t_mix;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    // shadow copy of the list contents and length
    logic signed [VALUE_W-1:0] list_words [CAPACITY];
    int unsigned               list_len;

    t_rsp        expected_rsps[$];
    int unsigned burst_left;
    int unsigned sent;
    int unsigned checked;
    int unsigned errors;
    int unsigned status_seen [4];

    insert_delete_array_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Shadow list update for one accepted request; returns the result the
    // block must give. Rejected actions leave the shadow untouched.
    function automatic t_rsp apply_action(t_req req);
        t_rsp        rsp;
        int unsigned k;
        rsp        = '0;
        rsp.status = ST_OK;
        case (req.action)
            ACT_APPEND: begin
                if (list_len >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    list_words[list_len] = req.value;
                    list_len++;
                end
            end
            ACT_INSERT: begin
                // range is checked before fullness
                if (req.position > list_len) begin
                    rsp.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (k = list_len; k > req.position; k--)
                        list_words[k] = list_words[k-1];
                    list_words[req.position] = req.value;
                    list_len++;
                end
            end
            ACT_DELETE: begin
                // emptiness is checked before range
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (req.position >= list_len) begin
                    rsp.status = ST_RANGE;
                end else begin
                    for (k = req.position + 1; k < list_len; k++)
                        list_words[k-1] = list_words[k];
                    list_len--;
                end
            end
            ACT_DROP: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    list_len--;
                    list_words[list_len] = '0;
                end
            end
            ACT_READ: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (req.position >= list_len) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.read_value = list_words[req.position];
                end
            end
            default: begin
                // spare codes: no change, plain ok
            end
        endcase
        rsp.count = list_len[CNT_W-1:0];
        return rsp;
    endfunction

    // Send one request. The sender runs in bursts; a burst that has run
    // out is followed by a gap of idle cycles with start low. Start is
    // only lowered when an idle gap follows, so it is never dropped and
    // raised in the same step.
    task automatic issue(input logic [2:0] act, input int unsigned pos,
                         input logic signed [VALUE_W-1:0] val);
        t_req        req;
        int unsigned gap;
        req.action   = act;
        req.position = pos[POS_W-1:0];
        req.value    = val;
        if (burst_left == 0) begin
            // now and then a long back-to-back stretch
            if ($urandom_range(4) == 0)
                burst_left = $urandom_range(60, 30);
            else
                burst_left = $urandom_range(8, 1);
            gap = $urandom_range(6, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        start <= 1'b1;
        i_req <= req;
        // accepted at the first edge that sees busy low
        do @(posedge i_clk); while (busy);
        expected_rsps.insert(expected_rsps.size(), apply_action(req));
        sent++;
    endtask

    // Every result is taken at the edge that ends its strobe cycle and
    // matched against the oldest outstanding expectation.
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (expected_rsps.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %p", $time, o_rsp);
            end else begin
                want = expected_rsps.pop_front();
                checked++;
                status_seen[want.status]++;
                if (o_rsp.status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_rsp.status);
                end
                if (o_rsp.read_value !== want.read_value) begin
                    errors++;
                    $display("%0t: read_value mismatch, expected %0d, got %0d",
                             $time, want.read_value, o_rsp.read_value);
                end
                if (o_rsp.count !== want.count) begin
                    errors++;
                    $display("%0t: count mismatch, expected %0d, got %0d",
                             $time, want.count, o_rsp.count);
                end
            end
        end
    end

    // every rejection on an empty list, plus a spare action code
    task automatic test_empty_list();
        issue(ACT_READ, 0, '0);
        issue(ACT_DELETE, 0, '0);
        issue(ACT_DROP, 0, '0);
        issue(ACT_INSERT, 1, VAL_MAX);     // past count
        issue(ACT_INSERT, 31, VAL_MIN);    // far past count
        issue(ACT_SPARE_LO, 0, VAL_MAX);
    endtask

    // insert at front, middle and end; delete in the middle; range errors
    task automatic test_shifting();
        int unsigned k;
        issue(ACT_INSERT, 0, VAL_MIN);
        issue(ACT_APPEND, 0, VAL_MAX);
        issue(ACT_INSERT, 1, '0);
        issue(ACT_INSERT, 3, -1);           // position equal to count
        for (k = 0; k < 4; k++)
            issue(ACT_READ, k, '0);
        issue(ACT_READ, 4, '0);             // one past the end
        issue(ACT_DELETE, 1, '0);
        issue(ACT_READ, 1, '0);
        issue(ACT_DELETE, 31, '0);
        issue(ACT_DROP, 0, '0);
        while (list_len > 0)
            issue(ACT_DROP, 0, '0);
    endtask

    // fill to capacity, then every rejection on a full list, plus a spare code, a read and deletes
    task automatic test_full_list();
        while (list_len < CAPACITY)
            issue(ACT_APPEND, 0, $urandom);
        issue(ACT_APPEND, 0, VAL_MIN);
        issue(ACT_INSERT, CAPACITY, VAL_MAX);     // valid position, but full
        issue(ACT_INSERT, CAPACITY + 1, VAL_MAX); // range wins over full
        issue(ACT_READ, CAPACITY - 1, '0);
        issue(ACT_READ, CAPACITY, '0);
        issue(ACT_SPARE_HI, 31, -1);
        issue(ACT_DELETE, CAPACITY - 1, '0);
        issue(ACT_DELETE, 0, '0);
    endtask

    // Mostly legal actions with positions inside the list, steered by a
    // mix that pushes the list to full and to empty; the rest is noise
    // over every code, position and value.
    task automatic test_random_sequences(input int unsigned n_reqs);
        t_mix                      mix;
        int unsigned               mix_left;
        int unsigned               roll;
        int unsigned               pos;
        logic [2:0]                act;
        logic signed [VALUE_W-1:0] val;
        mix_left = 0;
        repeat (n_reqs) begin
            if (mix_left == 0 || (mix == FILL_UP && list_len == CAPACITY && $urandom_range(3) == 0)
                              || (mix == DRAIN && list_len == 0)) begin
                mix      = t_mix'($urandom_range(2));
                mix_left = $urandom_range(40, 10);
            end
            mix_left--;
            val = $urandom;
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: val = VAL_MIN;
                    1: val = VAL_MAX;
                    2: val = '0;
                    default: val = -1;
                endcase
            end
            roll = $urandom_range(99);
            if (roll < 12) begin
                act = 3'($urandom_range(ACT_SPARE_HI));
                pos = $urandom_range(31);
            end else begin
                roll = $urandom_range(99);
                case (mix)
                    FILL_UP: act = roll < 45 ? ACT_APPEND : roll < 75 ? ACT_INSERT :
                                   roll < 90 ? ACT_READ : roll < 95 ? ACT_DELETE : ACT_DROP;
                    DRAIN:   act = roll < 35 ? ACT_DELETE : roll < 60 ? ACT_DROP :
                                   roll < 85 ? ACT_READ : roll < 92 ? ACT_APPEND : ACT_INSERT;
                    default: act = roll < 20 ? ACT_APPEND : roll < 40 ? ACT_INSERT :
                                   roll < 60 ? ACT_DELETE : roll < 75 ? ACT_DROP : ACT_READ;
                endcase
                if (act == ACT_INSERT)
                    pos = $urandom_range(list_len);
                else
                    pos = list_len == 0 ? 0 : $urandom_range(list_len - 1);
                // occasionally a position drawn over the whole field, often out of range
                if ($urandom_range(9) == 0)
                    pos = $urandom_range(31);
            end
            issue(act, pos, val);
        end
    endtask

    initial begin
        int unsigned drain_wait;
        burst_left = 0;
        list_len   = 0;
        sent       = 0;
        checked    = 0;
        errors     = 0;
        for (int s = 0; s < 4; s++)
            status_seen[s] = 0;
        for (int k = 0; k < CAPACITY; k++)
            list_words[k] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_shifting();
        test_full_list();
        test_random_sequences(RANDOM_REQS);

        // stop sending; wait for the last results, bounded
        start <= 1'b0;
        drain_wait = 0;
        while (expected_rsps.size() != 0 && drain_wait < 50) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (4) @(posedge i_clk);
        if (expected_rsps.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_rsps.size());
        end

        $display("Sent %0d requests over empty, partly filled and full lists;", sent);
        $display("checked %0d results: ok %0d, range %0d, full %0d, empty %0d.",
                 checked, status_seen[ST_OK], status_seen[ST_RANGE],
                 status_seen[ST_FULL], status_seen[ST_EMPTY]);
        if (errors == 0)
            $display("insert_delete_array_unit test passed");
        else
            $display("insert_delete_array_unit test failed");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #1000000;
        $display("insert_delete_array_unit test failed");
        $finish;
    end

endmodule
